// File: hdl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg: shared types and constants of the alarm clock controller
// Mode codes, event flag positions, icon codes, state and result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

  typedef enum logic [1:0] {
    MODE_SET_TIME  = 2'd0,
    MODE_SET_ALARM = 2'd1,
    MODE_RUNNING   = 2'd2,
    MODE_SOUNDING  = 2'd3
  } mode_t;

  // pending event flag positions
  localparam int EV_TICK   = 0;
  localparam int EV_BLINK  = 1;
  localparam int EV_HOUR   = 2;
  localparam int EV_MINUTE = 3;
  localparam int EV_MODE   = 4;
  localparam int EV_COUNT  = 5;

  // configuration register indexes
  localparam logic CFG_BLINK_DIVIDE = 1'b0;
  localparam logic CFG_RING_TIMEOUT = 1'b1;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;

  localparam logic [3:0] BLINK_DIVIDE_RESET = 4'd5;
  localparam logic [7:0] RING_TIMEOUT_RESET = 8'd50;

  localparam logic [1:0] CLK_ICON_OFF    = 2'd0;
  localparam logic [1:0] CLK_ICON_YELLOW = 2'd1;
  localparam logic [1:0] CLK_ICON_GREEN  = 2'd2;

  localparam logic [2:0] SPK_ICON_OFF    = 3'd0;
  localparam logic [2:0] SPK_ICON_GRAY   = 3'd1;
  localparam logic [2:0] SPK_ICON_YELLOW = 3'd2;
  localparam logic [2:0] SPK_ICON_GREEN  = 3'd3;
  localparam logic [2:0] SPK_ICON_RED    = 3'd4;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
  } hm_t;

  typedef struct packed {
    mode_t                mode;
    hm_t                  clk;
    hm_t                  wake;
    logic                 armed;
    logic                 sounding;
    logic [EV_COUNT-1:0]  pending;
    logic [3:0]           prescale;
    logic [7:0]           ring_cnt;
    logic                 clk_blink;
    logic                 setup_spk;
    logic                 ring_spk;
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic [1:0] clock_icon;
    logic [2:0] speaker_icon;
    logic       beeper_on;
    logic       alarm_armed;
  } result_t;

  localparam state_t STATE_RESET = '{
    mode:      MODE_SET_TIME,
    clk:       '0,
    wake:      '0,
    armed:     1'b0,
    sounding:  1'b0,
    pending:   '0,
    prescale:  4'd0,
    ring_cnt:  8'd0,
    clk_blink: 1'b1,
    setup_spk: 1'b1,
    ring_spk:  1'b0
  };

  function automatic logic [4:0] bump_hour(input logic [4:0] h);
    bump_hour = (h >= MAX_HOUR) ? 5'd0 : h + 5'd1;
  endfunction

  function automatic logic [5:0] bump_minute(input logic [5:0] m);
    bump_minute = (m >= MAX_MINUTE) ? 6'd0 : m + 6'd1;
  endfunction

  // one minute forward with carry into the hour
  function automatic hm_t advance_minute(input hm_t t);
    hm_t r;
    r = t;
    if (t.minutes >= MAX_MINUTE) begin
      r.minutes = 6'd0;
      r.hours   = bump_hour(t.hours);
    end else begin
      r.minutes = t.minutes + 6'd1;
    end
    advance_minute = r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/acc_core.sv
// ----------------------------------------------------------------------------
// acc_core: mode handlers of the alarm clock controller
// Merge new events into the pending flags and compute the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acc_core
  import acc_pkg::*;
(
  input  state_t     state_cur,
  input  logic       tick,
  input  logic       press_hour,
  input  logic       press_minute,
  input  logic       press_mode,
  input  logic [3:0] blink_divide,
  input  logic [7:0] ring_timeout,
  output state_t     state_nxt
);

  always_comb begin
    state_t              n;
    logic [EV_COUNT-1:0] pend;
    logic [3:0]          pre;
    logic [7:0]          rc;
    logic                armed_v;
    logic                set_time;

    n    = state_cur;
    pend = state_cur.pending;
    pre  = state_cur.prescale;

    if (tick) begin
      pend[EV_TICK] = 1'b1;
      pre = state_cur.prescale + 4'd1;
      if (pre >= blink_divide) begin
        pre = 4'd0;
        pend[EV_BLINK] = 1'b1;
      end
    end
    pend[EV_HOUR]   = pend[EV_HOUR] | press_hour;
    pend[EV_MINUTE] = pend[EV_MINUTE] | press_minute;
    pend[EV_MODE]   = pend[EV_MODE] | press_mode;
    n.prescale = pre;

    set_time = (state_cur.mode == MODE_SET_TIME);
    armed_v  = state_cur.armed;
    rc       = state_cur.ring_cnt;

    case (state_cur.mode)
      MODE_SET_TIME, MODE_SET_ALARM: begin
        // one event per pass, blink first
        if (pend[EV_BLINK]) begin
          pend[EV_BLINK] = 1'b0;
          if (set_time) n.clk_blink = ~state_cur.clk_blink;
          else          n.setup_spk = ~state_cur.setup_spk;
        end else if (pend[EV_HOUR]) begin
          pend[EV_HOUR] = 1'b0;
          if (set_time) n.clk.hours  = bump_hour(state_cur.clk.hours);
          else          n.wake.hours = bump_hour(state_cur.wake.hours);
        end else if (pend[EV_MINUTE]) begin
          pend[EV_MINUTE] = 1'b0;
          if (set_time) n.clk.minutes  = bump_minute(state_cur.clk.minutes);
          else          n.wake.minutes = bump_minute(state_cur.wake.minutes);
        end else if (pend[EV_MODE]) begin
          pend[EV_MODE] = 1'b0;
          n.mode = set_time ? MODE_SET_ALARM : MODE_RUNNING;
        end
      end
      MODE_RUNNING: begin
        armed_v = state_cur.armed ^ pend[EV_HOUR];
        pend[EV_HOUR] = 1'b0;
        n.armed = armed_v;
        if (armed_v && (state_cur.clk == state_cur.wake)) begin
          n.mode     = MODE_SOUNDING;
          n.sounding = 1'b1;
        end else if (pend[EV_MODE]) begin
          pend[EV_MODE] = 1'b0;
          n.mode = MODE_SET_TIME;
        end else if (pend[EV_TICK]) begin
          pend[EV_TICK] = 1'b0;
          n.clk = advance_minute(state_cur.clk);
        end
      end
      MODE_SOUNDING: begin
        if (pend[EV_TICK]) begin
          pend[EV_TICK] = 1'b0;
          rc = state_cur.ring_cnt + 8'd1;
          n.clk      = advance_minute(state_cur.clk);
          n.ring_spk = ~state_cur.ring_spk;
          // stop: the cleared wake time still takes this tick's minute
          if ((rc == ring_timeout) || pend[EV_MINUTE]) begin
            rc         = 8'd0;
            n.armed    = 1'b0;
            n.sounding = 1'b0;
            n.mode     = MODE_RUNNING;
            n.wake     = advance_minute('0);
          end else begin
            n.wake = advance_minute(state_cur.wake);
          end
          n.ring_cnt = rc;
        end
      end
      default: begin
        n = state_cur;
      end
    endcase

    n.pending = pend;
    state_nxt = n;
  end

endmodule

`default_nettype wire

// File: hdl/acc_disp.sv
// ----------------------------------------------------------------------------
// acc_disp: display and buzzer decode of the alarm clock controller
// Map the state after a pass to shown time, icon codes and buzzer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acc_disp
  import acc_pkg::*;
(
  input  state_t  state_cur,
  output result_t result
);

  always_comb begin
    result.mode          = state_cur.mode;
    result.shown_hours   = state_cur.clk.hours;
    result.shown_minutes = state_cur.clk.minutes;
    result.clock_icon    = CLK_ICON_GREEN;
    result.speaker_icon  = SPK_ICON_GRAY;
    result.beeper_on     = state_cur.sounding;
    result.alarm_armed   = state_cur.armed;
    case (state_cur.mode)
      MODE_SET_TIME: begin
        result.clock_icon = state_cur.clk_blink ? CLK_ICON_YELLOW : CLK_ICON_OFF;
      end
      MODE_SET_ALARM: begin
        result.shown_hours   = state_cur.wake.hours;
        result.shown_minutes = state_cur.wake.minutes;
        result.speaker_icon  = state_cur.setup_spk ? SPK_ICON_YELLOW : SPK_ICON_OFF;
      end
      MODE_RUNNING: begin
        result.speaker_icon = state_cur.armed ? SPK_ICON_GREEN : SPK_ICON_GRAY;
      end
      MODE_SOUNDING: begin
        result.shown_hours   = state_cur.wake.hours;
        result.shown_minutes = state_cur.wake.minutes;
        result.speaker_icon  = state_cur.ring_spk ? SPK_ICON_RED : SPK_ICON_OFF;
      end
      default: begin
        result.speaker_icon = SPK_ICON_GRAY;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/alarm_clock_controller_unit.sv
// ----------------------------------------------------------------------------
// alarm_clock_controller_unit: alarm clock controller, one main-loop pass per
// transaction
// Latency: the result is registered and shows up in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result channel does not stall;
// the state register loop through the mode handlers is combinational.
// Reset: synchronous, active low; clears the controller state, restores the
// configuration registers to their defaults and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_controller_unit
  import acc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one main-loop pass
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_tick_100ms,
  input  logic       in_press_hour,
  input  logic       in_press_minute,
  input  logic       in_press_mode,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_mode,
  output logic [4:0] out_shown_hours,
  output logic [5:0] out_shown_minutes,
  output logic [1:0] out_clock_icon,
  output logic [2:0] out_speaker_icon,
  output logic       out_beeper_on,
  output logic       out_alarm_armed,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  state_t     state_r;
  state_t     state_nxt;
  result_t    result_r;
  result_t    result_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [3:0] blink_divide_r;
  logic [7:0] ring_timeout_r;
  logic       in_accept;

  // Take a new transaction whenever the result register is empty or is
  // being drained in this same cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Hold the result until taken; refill on every accepted transaction.
  assign out_valid_nxt = in_accept | (out_valid_r & out_stall);

  acc_core u_core (
    .state_cur    (state_r),
    .tick         (in_tick_100ms),
    .press_hour   (in_press_hour),
    .press_minute (in_press_minute),
    .press_mode   (in_press_mode),
    .blink_divide (blink_divide_r),
    .ring_timeout (ring_timeout_r),
    .state_nxt    (state_nxt)
  );

  // Decode the display from the state as it stands after the pass.
  acc_disp u_disp (
    .state_cur (state_nxt),
    .result    (result_nxt)
  );

  // Controller state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  // Result payload: load on accept only.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_divide_r <= BLINK_DIVIDE_RESET;
      ring_timeout_r <= RING_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_DIVIDE: blink_divide_r <= cfg_wdata[3:0];
        CFG_RING_TIMEOUT: ring_timeout_r <= cfg_wdata;
        default: begin
          ring_timeout_r <= ring_timeout_r;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = result_r.mode;
  assign out_shown_hours   = result_r.shown_hours;
  assign out_shown_minutes = result_r.shown_minutes;
  assign out_clock_icon    = result_r.clock_icon;
  assign out_speaker_icon  = result_r.speaker_icon;
  assign out_beeper_on     = result_r.beeper_on;
  assign out_alarm_armed   = result_r.alarm_armed;

  // Stored time of day never leaves its range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.clk.hours <= MAX_HOUR) && (state_r.clk.minutes <= MAX_MINUTE) &&
    (state_r.wake.hours <= MAX_HOUR) && (state_r.wake.minutes <= MAX_MINUTE))
    else $error("time of day out of range");

  // Every accepted transaction shows up as a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // The buzzer drives exactly while the result reports the sounding mode.
  a_buzzer_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beeper_on == (out_mode == MODE_SOUNDING)))
    else $error("buzzer and mode disagree");

  // A drained result without a new transaction leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_accept && !out_stall) |=> !out_valid)
    else $error("result repeated after being taken");

endmodule

`default_nettype wire

// File: verif/acc_pass_checker.sv
// ----------------------------------------------------------------------------
// acc_pass_checker: result checker for the alarm clock controller
// Follows every accepted main-loop pass and register write, keeps its own
// copy of the controller state, queues the expected result of each pass and
// compares the results on the output channel field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_pass_checker
  import acc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_tick_100ms,
  input  logic       in_press_hour,
  input  logic       in_press_minute,
  input  logic       in_press_mode,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_mode,
  input  logic [4:0] out_shown_hours,
  input  logic [5:0] out_shown_minutes,
  input  logic [1:0] out_clock_icon,
  input  logic [2:0] out_speaker_icon,
  input  logic       out_beeper_on,
  input  logic       out_alarm_armed,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         errors
);

  logic [3:0]          blink_div;
  logic [7:0]          ring_limit;
  mode_t               cur_mode;
  hm_t                 clock_t;
  hm_t                 wake_t;
  logic                armed;
  logic                sounding;
  logic [EV_COUNT-1:0] flags;
  logic [3:0]          blink_cnt;
  logic [7:0]          ring_cnt;
  logic                clock_blink;
  logic                setup_blink;
  logic                ring_blink;
  result_t             due_results[$];
  int                  fail_cnt = 0;

  assign errors = fail_cnt;

  function automatic logic [4:0] next_hour(input logic [4:0] h);
    next_hour = (h >= 5'd23) ? 5'd0 : h + 5'd1;
  endfunction

  function automatic logic [5:0] next_min(input logic [5:0] m);
    next_min = (m >= 6'd59) ? 6'd0 : m + 6'd1;
  endfunction

  function automatic hm_t plus_minute(input hm_t t);
    hm_t r;
    r = t;
    r.minutes = next_min(t.minutes);
    if (r.minutes == 6'd0) r.hours = next_hour(t.hours);
    plus_minute = r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : follow
    result_t             want;
    logic [EV_COUNT-1:0] ev;
    hm_t                 t;
    logic                blk;
    mode_t               next_mode;
    if (!rst_n) begin
      blink_div   = BLINK_DIVIDE_RESET;
      ring_limit  = RING_TIMEOUT_RESET;
      cur_mode    = MODE_SET_TIME;
      clock_t     = '0;
      wake_t      = '0;
      armed       = 1'b0;
      sounding    = 1'b0;
      flags       = '0;
      blink_cnt   = 4'd0;
      ring_cnt    = 8'd0;
      clock_blink = 1'b1;
      setup_blink = 1'b1;
      ring_blink  = 1'b0;
      due_results.delete();
    end else begin
      // compare first, so a result can never meet the pass accepted at this edge
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("mode: expected no result, got %0d", out_mode);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          check_field("mode", 8'(want.mode), 8'(out_mode));
          check_field("shown_hours", 8'(want.shown_hours), 8'(out_shown_hours));
          check_field("shown_minutes", 8'(want.shown_minutes), 8'(out_shown_minutes));
          check_field("clock_icon", 8'(want.clock_icon), 8'(out_clock_icon));
          check_field("speaker_icon", 8'(want.speaker_icon), 8'(out_speaker_icon));
          check_field("beeper_on", 8'(want.beeper_on), 8'(out_beeper_on));
          check_field("alarm_armed", 8'(want.alarm_armed), 8'(out_alarm_armed));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_BLINK_DIVIDE: blink_div  = cfg_wdata[3:0];
          CFG_RING_TIMEOUT: ring_limit = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        ev        = flags;
        next_mode = cur_mode;
        if (in_tick_100ms) begin
          ev[EV_TICK] = 1'b1;
          blink_cnt   = blink_cnt + 4'd1;
          if (blink_cnt >= blink_div) begin
            blink_cnt    = 4'd0;
            ev[EV_BLINK] = 1'b1;
          end
        end
        if (in_press_hour)   ev[EV_HOUR]   = 1'b1;
        if (in_press_minute) ev[EV_MINUTE] = 1'b1;
        if (in_press_mode)   ev[EV_MODE]   = 1'b1;

        case (cur_mode)
          MODE_SET_TIME, MODE_SET_ALARM: begin
            // both setup screens take one flag per pass, blink first
            if (cur_mode == MODE_SET_TIME) begin
              t   = clock_t;
              blk = clock_blink;
            end else begin
              t   = wake_t;
              blk = setup_blink;
            end
            if (ev[EV_BLINK]) begin
              ev[EV_BLINK] = 1'b0;
              blk          = ~blk;
            end else if (ev[EV_HOUR]) begin
              ev[EV_HOUR] = 1'b0;
              t.hours     = next_hour(t.hours);
            end else if (ev[EV_MINUTE]) begin
              ev[EV_MINUTE] = 1'b0;
              t.minutes     = next_min(t.minutes);
            end else if (ev[EV_MODE]) begin
              ev[EV_MODE] = 1'b0;
              if (cur_mode == MODE_SET_TIME) next_mode = MODE_SET_ALARM;
              else next_mode = MODE_RUNNING;
            end
            if (cur_mode == MODE_SET_TIME) begin
              clock_t     = t;
              clock_blink = blk;
            end else begin
              wake_t      = t;
              setup_blink = blk;
            end
          end
          MODE_RUNNING: begin
            if (ev[EV_HOUR]) begin
              ev[EV_HOUR] = 1'b0;
              armed       = ~armed;
            end
            if (armed && clock_t == wake_t) begin
              next_mode = MODE_SOUNDING;
              sounding  = 1'b1;
            end else if (ev[EV_MODE]) begin
              ev[EV_MODE] = 1'b0;
              next_mode   = MODE_SET_TIME;
            end else if (ev[EV_TICK]) begin
              ev[EV_TICK] = 1'b0;
              clock_t     = plus_minute(clock_t);
            end
          end
          default: begin
            // sounding acts on ticks only; a minute press is tested, never cleared
            if (ev[EV_TICK]) begin
              ev[EV_TICK] = 1'b0;
              ring_cnt    = ring_cnt + 8'd1;
              clock_t     = plus_minute(clock_t);
              ring_blink  = ~ring_blink;
              if (ring_cnt == ring_limit || ev[EV_MINUTE]) begin
                ring_cnt  = 8'd0;
                armed     = 1'b0;
                sounding  = 1'b0;
                wake_t    = '0;
                next_mode = MODE_RUNNING;
              end
              wake_t = plus_minute(wake_t);
            end
          end
        endcase
        flags    = ev;
        cur_mode = next_mode;

        want.mode        = cur_mode;
        want.clock_icon  = CLK_ICON_GREEN;
        want.beeper_on   = sounding;
        want.alarm_armed = armed;
        case (cur_mode)
          MODE_SET_TIME: begin
            {want.shown_hours, want.shown_minutes} = clock_t;
            want.clock_icon   = clock_blink ? CLK_ICON_YELLOW : CLK_ICON_OFF;
            want.speaker_icon = SPK_ICON_GRAY;
          end
          MODE_SET_ALARM: begin
            {want.shown_hours, want.shown_minutes} = wake_t;
            want.speaker_icon = setup_blink ? SPK_ICON_YELLOW : SPK_ICON_OFF;
          end
          MODE_RUNNING: begin
            {want.shown_hours, want.shown_minutes} = clock_t;
            want.speaker_icon = armed ? SPK_ICON_GREEN : SPK_ICON_GRAY;
          end
          default: begin
            {want.shown_hours, want.shown_minutes} = wake_t;
            want.speaker_icon = ring_blink ? SPK_ICON_RED : SPK_ICON_OFF;
          end
        endcase
        due_results.push_back(want);
      end
    end
  end

endmodule

// File: verif/alarm_clock_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// alarm_clock_controller_unit_tb: testbench of the alarm clock controller
// Drives main-loop passes with random gaps and result-side stalls, walks the
// controller through setting the time, setting the alarm, arming, ringing and
// stopping under several register settings, and mixes in random button noise.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_clock_controller_unit_tb;
  import acc_pkg::*;

  // far above the slowest correct run, including full 256-tick rings
  localparam int CYCLE_LIMIT  = 300000;
  // passes per register setting before moving on
  localparam int PHASE_PASSES = 90;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_tick_100ms   = 1'b0;
  logic       in_press_hour   = 1'b0;
  logic       in_press_minute = 1'b0;
  logic       in_press_mode   = 1'b0;
  logic       out_stall       = 1'b0;
  logic       cfg_we          = 1'b0;
  logic       cfg_index       = CFG_BLINK_DIVIDE;
  logic [7:0] cfg_wdata       = 8'd0;

  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_mode;
  logic [4:0] out_shown_hours;
  logic [5:0] out_shown_minutes;
  logic [1:0] out_clock_icon;
  logic [2:0] out_speaker_icon;
  logic       out_beeper_on;
  logic       out_alarm_armed;

  int errors;

  // percent chance of an idle cycle on the input side and a stall on the output
  int idle_pct  = 38;
  int stall_pct = 38;

  int passes_sent  = 0;
  int results_seen = 0;
  int cycles       = 0;

  // last result seen on the output channel, used to steer the stimulus
  logic [1:0] seen_mode    = MODE_SET_TIME;
  logic [4:0] seen_hours   = 5'd0;
  logic [5:0] seen_minutes = 6'd0;
  logic       seen_armed   = 1'b0;

  // ring timeout now programmed, to size the ringing stretch
  logic [7:0] cur_tmo = RING_TIMEOUT_RESET;

  alarm_clock_controller_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick_100ms     (in_tick_100ms),
    .in_press_hour     (in_press_hour),
    .in_press_minute   (in_press_minute),
    .in_press_mode     (in_press_mode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode          (out_mode),
    .out_shown_hours   (out_shown_hours),
    .out_shown_minutes (out_shown_minutes),
    .out_clock_icon    (out_clock_icon),
    .out_speaker_icon  (out_speaker_icon),
    .out_beeper_on     (out_beeper_on),
    .out_alarm_armed   (out_alarm_armed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  acc_pass_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick_100ms     (in_tick_100ms),
    .in_press_hour     (in_press_hour),
    .in_press_minute   (in_press_minute),
    .in_press_mode     (in_press_mode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode          (out_mode),
    .out_shown_hours   (out_shown_hours),
    .out_shown_minutes (out_shown_minutes),
    .out_clock_icon    (out_clock_icon),
    .out_speaker_icon  (out_speaker_icon),
    .out_beeper_on     (out_beeper_on),
    .out_alarm_armed   (out_alarm_armed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .errors            (errors)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random; hold it open during reset.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Track the latest result and how many have arrived.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_mode    = out_mode;
      seen_hours   = out_shown_hours;
      seen_minutes = out_shown_minutes;
      seen_armed   = out_alarm_armed;
      results_seen++;
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one pass after a random gap and hold it until the block takes it.
  task automatic send_pass(input logic tk, input logic hr, input logic mn,
                           input logic md);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_tick_100ms   <= tk;
    in_press_hour   <= hr;
    in_press_minute <= mn;
    in_press_mode   <= md;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    passes_sent++;
  endtask

  // Drop valid and wait until every pass has produced its result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_seen != passes_sent) @(negedge clk);
  endtask

  // One pass, then look at what it did.
  task automatic probe(input logic tk, input logic hr, input logic mn, input logic md);
    send_pass(tk, hr, mn, md);
    settle();
  endtask

  // Write one register with the block drained.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    settle();
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Program both registers; random upper bits on the 4-bit divider field.
  task automatic set_regs(input logic [3:0] div, input logic [7:0] tmo);
    logic [3:0] junk;
    junk = 4'($urandom_range(15));
    write_reg(CFG_BLINK_DIVIDE, {junk, div});
    write_reg(CFG_RING_TIMEOUT, tmo);
    cur_tmo = tmo;
  endtask

  // Press mode (or stop a ringing alarm) until the wanted screen shows.
  task automatic goto_mode(input mode_t want);
    int n;
    for (n = 0; n < 40 && seen_mode != want; n++) begin
      if (seen_mode == MODE_SOUNDING) probe(1'b1, 1'b0, 1'b1, 1'b0);
      else probe(1'b0, 1'b0, 1'b0, 1'b1);
    end
  endtask

  // Step hours, then minutes, on a setup screen until it shows the target.
  task automatic dial(input mode_t scr, input logic [4:0] th, input logic [5:0] tm);
    int n;
    for (n = 0; n < 60 && seen_mode == scr && seen_hours != th; n++)
      probe(1'b0, 1'b1, 1'b0, 1'b0);
    for (n = 0; n < 130 && seen_mode == scr && seen_minutes != tm; n++)
      probe(1'b0, 1'b0, 1'b1, 1'b0);
  endtask

  // Full alarm sequence: set the clock, set the wake time zero to four minutes
  // ahead, arm, let it ring, and either let it time out or stop it.
  task automatic alarm_round();
    logic [4:0] ch;
    logic [4:0] wh;
    logic [5:0] cm;
    logic [5:0] wm;
    int         lead;
    int         ring_len;
    int         n;
    logic       quiet;
    settle();
    goto_mode(MODE_SET_TIME);
    ch = seen_hours;
    n  = seen_minutes + $urandom_range(2);
    cm = 6'((n >= 60) ? n - 60 : n);
    // now and then dial a far time to reach the late hours and minute wraps
    if ($urandom_range(5) == 0) begin
      ch = 5'($urandom_range(23));
      cm = 6'($urandom_range(59));
    end
    dial(MODE_SET_TIME, ch, cm);

    goto_mode(MODE_SET_ALARM);
    lead = $urandom_range(4);
    n    = cm + lead;
    if (n >= 60) begin
      wm = 6'(n - 60);
      wh = (ch == 5'd23) ? 5'd0 : ch + 5'd1;
    end else begin
      wm = 6'(n);
      wh = ch;
    end
    dial(MODE_SET_ALARM, wh, wm);

    goto_mode(MODE_RUNNING);
    if (seen_mode == MODE_RUNNING && !seen_armed) probe(1'b0, 1'b1, 1'b0, 1'b0);

    // Run open loop: tick up to the wake time, then through the ring. A quiet
    // round lets the timeout end it; otherwise stray presses cut it short.
    ring_len = (cur_tmo == 8'd0) ? 256 : cur_tmo;
    quiet    = (cur_tmo == 8'd0) || $urandom_range(1);
    for (n = 0; n < (lead + 3 + ring_len) * 5 / 4; n++) begin
      if (quiet) send_pass($urandom_range(9) != 0, 1'b0, 1'b0, 1'b0);
      else send_pass($urandom_range(9) != 0, $urandom_range(59) == 0,
                     $urandom_range(15) == 0, $urandom_range(49) == 0);
    end
  endtask

  // Random buttons and ticks with no plan behind them.
  task automatic noise_burst();
    int n;
    int len;
    len = $urandom_range(10, 40);
    for (n = 0; n < len; n++)
      send_pass(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom_range(3) == 0);
  endtask

  initial begin : stimulus
    int ph;
    int goal;
    int code;
    logic [3:0] div;
    logic [7:0] tmo;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: through both setup screens, arm with clock and wake
    // both at midnight so it rings at once, ring one tick, idle, stop it with
    // a minute press on a tick, then leave that press pending.
    send_pass(1'b0, 1'b0, 1'b0, 1'b1);
    send_pass(1'b0, 1'b0, 1'b0, 1'b1);
    send_pass(1'b0, 1'b1, 1'b0, 1'b0);
    send_pass(1'b1, 1'b0, 1'b0, 1'b0);
    send_pass(1'b0, 1'b0, 1'b0, 1'b0);
    send_pass(1'b1, 1'b0, 1'b1, 1'b0);
    send_pass(1'b0, 1'b0, 1'b0, 1'b0);
    // every combination of the four input bits
    for (code = 0; code < 16; code++)
      send_pass(code[3], code[2], code[1], code[0]);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;  // keep the reset settings
        1: set_regs(4'd0, 8'd3);      // every tick blinks
        2: set_regs(4'd1, 8'd1);
        3: set_regs(4'd15, 8'd255);
        4: set_regs(4'd7, 8'd0);      // ring count has to wrap to stop
        default: begin
          div = 4'($urandom_range(1, 14));
          tmo = 8'($urandom_range(2, 254));
          set_regs(div, tmo);
        end
      endcase
      // one whole setting runs back to back with no gaps or stalls
      idle_pct  = (ph == 2) ? 0 : 38;
      stall_pct = (ph == 2) ? 0 : 38;
      goal = passes_sent + PHASE_PASSES;
      while (passes_sent < goal) begin
        if ($urandom_range(9) < 6) alarm_round();
        else noise_burst();
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
